>>> src/dhrs_pkg.sv
// Shared types and constants for the disk head request scheduler.
`timescale 1ns / 1ps
`default_nettype none
package dhrs_pkg;

  localparam int DEPTH_DEF      = 64;
  localparam int TRACK_BITS_DEF = 16;
  localparam int FIELD_W        = 16;
  localparam int STAMP_W        = 16;
  localparam int POL_W          = 3;

  localparam logic [POL_W-1:0] POL_FIFO  = 3'd0;
  localparam logic [POL_W-1:0] POL_SSTF  = 3'd1;
  localparam logic [POL_W-1:0] POL_LOOK  = 3'd2;
  localparam logic [POL_W-1:0] POL_CLOOK = 3'd3;
  localparam logic [POL_W-1:0] POL_FLOOK = 3'd4;

  localparam logic REG_POLICY = 1'b0;

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_SCAN = 2'd1,
    OP_DEL  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    HOW_OLDEST = 3'd0,
    HOW_NEAR   = 3'd1,
    HOW_ABOVE  = 3'd2,
    HOW_LOWEST = 3'd3,
    HOW_FWD    = 3'd4,
    HOW_REV    = 3'd5
  } how_e;

  typedef struct packed {
    logic               grant_valid;
    logic [FIELD_W-1:0] grant_id;
    logic [FIELD_W-1:0] grant_track;
    logic               table_full_error;
    logic               all_empty;
  } res_t;

endpackage
`default_nettype wire

>>> src/dhrs_if.sv
// Request and grant channel interfaces for the disk head request scheduler.
`timescale 1ns / 1ps
`default_nettype none
interface dhrs_req_if import dhrs_pkg::*;;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [FIELD_W-1:0] request_id;
  logic [FIELD_W-1:0] request_track;
  logic [FIELD_W-1:0] head_track;

  modport source (output valid, kind, request_id, request_track, head_track, input ready);
  modport sink   (input valid, kind, request_id, request_track, head_track, output ready);
endinterface

interface dhrs_rsp_if import dhrs_pkg::*;;
  logic               valid;
  logic               ready;
  logic               grant_valid;
  logic [FIELD_W-1:0] grant_id;
  logic [FIELD_W-1:0] grant_track;
  logic               table_full_error;
  logic               all_empty;

  modport source (output valid, grant_valid, grant_id, grant_track, table_full_error,
                  all_empty, input ready);
  modport sink   (input valid, grant_valid, grant_id, grant_track, table_full_error,
                  all_empty, output ready);
endinterface
`default_nettype wire

>>> src/dhrs_cell.sv
// One table slot of the scheduler, with its stage of the operation token chain.
`timescale 1ns / 1ps
`default_nettype none
module dhrs_cell import dhrs_pkg::*; #(
  parameter int  DEPTH      = DEPTH_DEF,
  parameter int  TRACK_BITS = TRACK_BITS_DEF,
  parameter int  IDX        = 0,
  parameter type tok_t      = logic
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  tok_t      tok_i,
  output tok_t      tok_o
);

  localparam int SW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic                  vld_q, vld_d;
  logic [TRACK_BITS-1:0] trk_q, trk_d;
  logic [FIELD_W-1:0]    id_q, id_d;
  logic                  qs_q, qs_d;
  logic [STAMP_W-1:0]    st_q, st_d;
  tok_t                  tok_q, tok_d;

  logic                  ge, le, ok, inq, better;
  logic [TRACK_BITS-1:0] dif, key;
  logic [STAMP_W-1:0]    age;

  always_comb begin
    ge  = trk_q >= tok_i.head;
    le  = trk_q <= tok_i.head;
    dif = ge ? (trk_q - tok_i.head) : (tok_i.head - trk_q);
    age = tok_i.now - st_q;
    inq = !tok_i.use_q || (qs_q == tok_i.q);
    ok  = 1'b1;
    key = dif;
    case (tok_i.how)
      HOW_OLDEST: key = '0;
      HOW_NEAR:   key = dif;
      HOW_ABOVE:  ok  = ge;
      HOW_LOWEST: key = trk_q;
      HOW_FWD:    ok  = tok_i.up ? ge : le;
      HOW_REV:    ok  = tok_i.up ? !ge : !le;
      default:    key = '0;
    endcase
    better = !tok_i.found || (key < tok_i.bkey) ||
             ((key == tok_i.bkey) && (age > tok_i.bage));
  end

  always_comb begin
    vld_d = vld_q;
    trk_d = trk_q;
    id_d  = id_q;
    qs_d  = qs_q;
    st_d  = st_q;
    tok_d = tok_i;
    if (tok_i.go) begin
      case (tok_i.op)
        OP_ADD: begin
          if (!vld_q && !tok_i.found) begin
            vld_d       = 1'b1;
            trk_d       = tok_i.trk;
            id_d        = tok_i.ident;
            qs_d        = tok_i.qsel_new;
            st_d        = tok_i.now;
            tok_d.found = 1'b1;
            tok_d.slot  = SW'(IDX);
          end
          tok_d.cnt_all = tok_i.cnt_all + CW'(vld_d);
        end
        OP_SCAN: begin
          tok_d.cnt_all = tok_i.cnt_all + CW'(vld_q);
          tok_d.cnt_q   = tok_i.cnt_q + CW'(vld_q && inq);
          if (vld_q && inq && ok && better) begin
            tok_d.found = 1'b1;
            tok_d.slot  = SW'(IDX);
            tok_d.bkey  = key;
            tok_d.bage  = age;
            tok_d.trk   = trk_q;
            tok_d.ident = id_q;
          end
        end
        OP_DEL: begin
          if (tok_i.slot == SW'(IDX)) begin
            vld_d = 1'b0;
          end
        end
        default: tok_d = tok_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      tok_q <= '0;
    end else begin
      vld_q <= vld_d;
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    trk_q <= trk_d;
    id_q  <= id_d;
    qs_q  <= qs_d;
    st_q  <= st_d;
  end

  assign tok_o = tok_q;

endmodule
`default_nettype wire

>>> src/disk_head_request_scheduler_unit.sv
// Top level of the disk head request scheduler: sequencer, cell chain, APB register.
`timescale 1ns / 1ps
`default_nettype none
// Pending-request table for a disk head with selectable policy (FIFO, SSTF, LOOK,
// C-LOOK, F-LOOK). The table is a chain of DEPTH cells, one request per cell; every
// operation is a token that walks the chain one cell per cycle, so one pass runs
// through the injection register and all DEPTH cells. An add takes one pass. A pick
// takes a selection pass plus a release pass; C-LOOK with nothing at or above the
// head, LOOK or F-LOOK with an empty active queue, and F-LOOK with nothing ahead of
// the head each add one more selection pass. One item is in work at a time; a
// finished result sits in the output register while the next item is taken.
// policy_mode lives at byte address 0 of the APB port and may only be written while
// idle.
module disk_head_request_scheduler_unit import dhrs_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int TRACK_BITS = TRACK_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  dhrs_req_if.sink         req_i,
  dhrs_rsp_if.source       rsp_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int SW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  typedef struct packed {
    logic                  go;
    op_e                   op;
    how_e                  how;
    logic                  use_q;
    logic                  q;
    logic                  up;
    logic [TRACK_BITS-1:0] head;
    logic [STAMP_W-1:0]    now;
    logic [TRACK_BITS-1:0] trk;      // new entry on add, best so far on scan
    logic [FIELD_W-1:0]    ident;
    logic                  qsel_new;
    logic                  found;
    logic [SW-1:0]         slot;
    logic [TRACK_BITS-1:0] bkey;
    logic [STAMP_W-1:0]    bage;
    logic [CW-1:0]         cnt_all;
    logic [CW-1:0]         cnt_q;
  } tok_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  // Token chain: chain[0] is the injected token, chain[DEPTH] the returning one.
  tok_t chain [DEPTH+1];

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    dhrs_cell #(
      .DEPTH      (DEPTH),
      .TRACK_BITS (TRACK_BITS),
      .IDX        (g),
      .tok_t      (tok_t)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .tok_i (chain[g]),
      .tok_o (chain[g+1])
    );
  end

  state_e                state_q, state_d;
  tok_t                  inj_q, inj_d;
  logic [POL_W-1:0]      pol_q;
  logic [STAMP_W-1:0]    stamp_q, stamp_d;
  logic                  sweep_q, sweep_d;
  logic                  aq_q, aq_d;
  logic                  ltv_q, ltv_d;
  logic [TRACK_BITS-1:0] ltt_q, ltt_d;
  logic                  pass0_q, pass0_d;
  res_t                  res_q, res_d;
  res_t                  out_q;
  logic                  out_v_q;

  tok_t                  ret, nt, tok_new;
  logic                  req_acc, out_free;
  logic [TRACK_BITS-1:0] head_trk, add_trk, ref_trk;
  logic                  qs_new;

  assign chain[0] = inj_q;
  assign ret      = chain[DEPTH];

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;
  assign out_free    = !out_v_q || rsp_o.ready;

  assign head_trk = TRACK_BITS'(req_i.head_track);
  assign add_trk  = TRACK_BITS'(req_i.request_track);
  assign ref_trk  = ltv_q ? ltt_q : head_trk;

  // Queue filing of a new request (LOOK sides against last target, F-LOOK freeze).
  always_comb begin
    if (pol_q == POL_FLOOK) begin
      qs_new = ltv_q ? !aq_q : aq_q;
    end else if (sweep_q) begin
      qs_new = (add_trk >= ref_trk) ? 1'b0 : 1'b1;
    end else begin
      qs_new = (add_trk <= ref_trk) ? 1'b1 : 1'b0;
    end
  end

  // First token of an item.
  always_comb begin
    tok_new          = '0;
    tok_new.go       = 1'b1;
    tok_new.op       = req_i.kind ? OP_SCAN : OP_ADD;
    tok_new.head     = head_trk;
    tok_new.now      = stamp_q;
    tok_new.trk      = add_trk;
    tok_new.ident    = req_i.request_id;
    tok_new.qsel_new = qs_new;
    tok_new.up       = 1'b1;
    tok_new.how      = HOW_OLDEST;
    case (pol_q)
      POL_SSTF:  tok_new.how = HOW_NEAR;
      POL_CLOOK: tok_new.how = HOW_ABOVE;
      POL_LOOK: begin
        tok_new.how   = HOW_NEAR;
        tok_new.use_q = 1'b1;
        tok_new.q     = aq_q;
      end
      POL_FLOOK: begin
        tok_new.how   = HOW_FWD;
        tok_new.use_q = 1'b1;
        tok_new.q     = aq_q;
        tok_new.up    = sweep_q;
      end
      default:   tok_new.how = HOW_OLDEST;
    endcase
  end

  // Pass sequencer: decides what follows when a token comes back.
  always_comb begin
    state_d = state_q;
    inj_d   = '0;
    stamp_d = stamp_q;
    sweep_d = sweep_q;
    aq_d    = aq_q;
    ltv_d   = ltv_q;
    ltt_d   = ltt_q;
    pass0_d = pass0_q;
    res_d   = res_q;

    nt         = ret;
    nt.go      = 1'b1;
    nt.found   = 1'b0;
    nt.bkey    = '0;
    nt.bage    = '0;
    nt.cnt_all = '0;
    nt.cnt_q   = '0;

    case (state_q)
      ST_IDLE: begin
        if (req_acc) begin
          inj_d   = tok_new;
          pass0_d = 1'b1;
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (ret.go) begin
          pass0_d = 1'b0;
          case (ret.op)
            OP_ADD: begin
              res_d                  = '0;
              res_d.table_full_error = !ret.found;
              res_d.all_empty        = (ret.cnt_all == '0);
              if (ret.found) begin
                stamp_d = stamp_q + 1'b1;
              end
              state_d = ST_DONE;
            end
            OP_DEL: state_d = ST_DONE;
            OP_SCAN: begin
              if (pass0_q && ret.cnt_all == '0) begin
                res_d           = '0;
                res_d.all_empty = 1'b1;
                state_d         = ST_DONE;
              end else if (pol_q == POL_LOOK && pass0_q && ret.cnt_q == '0) begin
                // active sweep ran dry: swap queues and reverse
                aq_d    = !aq_q;
                sweep_d = !sweep_q;
                nt.q    = !aq_q;
                inj_d   = nt;
              end else if (pol_q == POL_FLOOK && pass0_q && ret.cnt_q == '0) begin
                aq_d    = !aq_q;
                nt.q    = !aq_q;
                inj_d   = nt;
              end else if (pol_q == POL_CLOOK && ret.how == HOW_ABOVE && !ret.found) begin
                nt.how  = HOW_LOWEST;   // wrap to the lowest track
                inj_d   = nt;
              end else if (pol_q == POL_FLOOK && ret.how == HOW_FWD && !ret.found) begin
                nt.how  = HOW_REV;      // nothing ahead: turn around
                sweep_d = !sweep_q;
                inj_d   = nt;
              end else if (ret.found) begin
                res_d                  = '0;
                res_d.grant_valid      = 1'b1;
                res_d.grant_id         = ret.ident;
                res_d.grant_track      = FIELD_W'(ret.trk);
                res_d.all_empty        = (ret.cnt_all == CW'(1));
                ltv_d                  = 1'b1;
                ltt_d                  = ret.trk;
                nt.op                  = OP_DEL;
                inj_d                  = nt;
              end else begin
                res_d           = '0;
                res_d.all_empty = (ret.cnt_all == '0);
                state_d         = ST_DONE;
              end
            end
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      inj_q   <= '0;
      stamp_q <= '0;
      sweep_q <= 1'b1;
      aq_q    <= 1'b0;
      ltv_q   <= 1'b0;
      ltt_q   <= '0;
      pass0_q <= 1'b0;
      out_v_q <= 1'b0;
      pol_q   <= POL_FIFO;
    end else begin
      state_q <= state_d;
      inj_q   <= inj_d;
      stamp_q <= stamp_d;
      sweep_q <= sweep_d;
      aq_q    <= aq_d;
      ltv_q   <= ltv_d;
      ltt_q   <= ltt_d;
      pass0_q <= pass0_d;
      if (state_q == ST_DONE && out_free) begin
        out_v_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_v_q <= 1'b0;
      end
      if (psel && penable && pwrite && paddr[2] == REG_POLICY) begin
        pol_q <= pwdata[POL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (state_q == ST_DONE && out_free) begin
      out_q <= res_q;
    end
  end

  assign rsp_o.valid            = out_v_q;
  assign rsp_o.grant_valid      = out_q.grant_valid;
  assign rsp_o.grant_id         = out_q.grant_id;
  assign rsp_o.grant_track      = out_q.grant_track;
  assign rsp_o.table_full_error = out_q.table_full_error;
  assign rsp_o.all_empty        = out_q.all_empty;

  // APB register file: a single register, always ready.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_POLICY) ? {{(32-POL_W){1'b0}}, pol_q} : '0;

endmodule
`default_nettype wire
